// ----- rtl/aus_pkg.sv -----
// shared types and constants of the ansi/utf8 segmenter
package aus_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W = 6;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned MAX_ESC_LEN = 32;

	localparam logic [BYTE_W-1:0] CH_ESC = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
	localparam logic [BYTE_W-1:0] PARAM_LO = 8'h30;
	localparam logic [BYTE_W-1:0] PARAM_HI = 8'h3F;
	localparam logic [BYTE_W-1:0] INTER_LO = 8'h20;
	localparam logic [BYTE_W-1:0] INTER_HI = 8'h2F;
	localparam logic [BYTE_W-1:0] TERM_LO = 8'h40;
	localparam logic [BYTE_W-1:0] TERM_HI = 8'h7E;
	localparam logic [BYTE_W-1:0] CONT_LO = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_HI = 8'hBF;
	localparam logic [BYTE_W-1:0] LEN_MAX = 8'hFF;

	localparam logic [KIND_W-1:0] KIND_TEXT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ESC = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CSI = 2'd2;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_TEXT,
		MODE_ESC,
		MODE_PARM,
		MODE_INTR
	} mode_t;

	// segments of one byte: optional head, a run of one-byte text, optional tail
	typedef struct packed {
		logic              head_v;
		logic [BYTE_W-1:0] head_len;
		logic [KIND_W-1:0] head_kind;
		logic [CNT_W-1:0]  ones;
		logic              tail_v;
		logic [BYTE_W-1:0] tail_len;
		logic [KIND_W-1:0] tail_kind;
		logic              eos;
	} seg_desc_t;

endpackage

// ----- rtl/aus_parse.sv -----
// input register and byte parser that turns each byte into a segment descriptor
module aus_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              load_ok,
	output logic              desc_load,
	output aus_pkg::seg_desc_t desc
);
	import aus_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eos_s1;

	mode_t             mode_q, mode_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	logic              desc_empty;
	logic              consume;

	assign desc_empty = !desc.head_v && (desc.ones == '0) && !desc.tail_v;
	assign consume = valid_s1 && (desc_empty || load_ok);
	assign desc_load = valid_s1 && !desc_empty && load_ok;
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eos_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q <= '0;
			cnt_q <= '0;
		end else if (consume) begin
			mode_q <= mode_d;
			len_q <= len_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		logic is_cont;
		logic is_esc;
		logic fits;
		logic fresh;
		is_cont = (byte_s1 >= CONT_LO) && (byte_s1 <= CONT_HI);
		is_esc = (byte_s1 == CH_ESC);
		fits = ({2'b00, cnt_q} < (CNT_W+2)'(MAX_ESC_LEN));
		fresh = 1'b0;
		mode_d = mode_q;
		len_d = len_q;
		cnt_d = cnt_q;
		desc = '0;
		desc.head_kind = KIND_TEXT;
		desc.tail_kind = KIND_TEXT;
		desc.eos = eos_s1;

		case (mode_q)
			MODE_IDLE: begin
				fresh = 1'b1;
			end
			MODE_TEXT: begin
				if (is_cont) begin
					len_d = (len_q == LEN_MAX) ? LEN_MAX : len_q + 1'b1;
				end else begin
					desc.head_v = 1'b1;
					desc.head_len = len_q;
					fresh = 1'b1;
				end
			end
			MODE_ESC: begin
				if (byte_s1 == CH_LBRACKET || byte_s1 == CH_RBRACKET) begin
					mode_d = MODE_PARM;
					cnt_d = CNT_W'(2);
				end else begin
					desc.head_v = 1'b1;
					desc.head_len = BYTE_W'(2);
					desc.head_kind = KIND_ESC;
					mode_d = MODE_IDLE;
				end
			end
			MODE_PARM, MODE_INTR: begin
				if (fits && byte_s1 >= PARAM_LO && byte_s1 <= PARAM_HI
						&& mode_q == MODE_PARM) begin
					cnt_d = cnt_q + 1'b1;
				end else if (fits && byte_s1 >= INTER_LO && byte_s1 <= INTER_HI) begin
					cnt_d = cnt_q + 1'b1;
					mode_d = MODE_INTR;
				end else if (fits && byte_s1 >= TERM_LO && byte_s1 <= TERM_HI) begin
					desc.head_v = 1'b1;
					desc.head_len = BYTE_W'({1'b0, cnt_q} + 1'b1);
					desc.head_kind = KIND_CSI;
					cnt_d = '0;
					mode_d = MODE_IDLE;
				end else begin
					// failed sequence: held bytes become one-byte text; a continuation byte keeps the last one open
					cnt_d = '0;
					mode_d = MODE_TEXT;
					if (is_cont) begin
						desc.ones = cnt_q - 1'b1;
						len_d = BYTE_W'(2);
					end else begin
						desc.ones = cnt_q;
						fresh = 1'b1;
					end
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		if (fresh) begin
			if (is_esc) begin
				mode_d = MODE_ESC;
				cnt_d = CNT_W'(1);
			end else begin
				mode_d = MODE_TEXT;
				len_d = BYTE_W'(1);
			end
		end

		if (eos_s1) begin
			case (mode_d)
				MODE_TEXT: begin
					desc.tail_v = 1'b1;
					desc.tail_len = len_d;
				end
				MODE_ESC: begin
					desc.tail_v = 1'b1;
					desc.tail_len = BYTE_W'(1);
				end
				MODE_PARM, MODE_INTR: begin
					desc.ones = cnt_d;
				end
				default: begin
				end
			endcase
			mode_d = MODE_IDLE;
			len_d = '0;
			cnt_d = '0;
		end
	end

endmodule

// ----- rtl/aus_expand.sv -----
// result register that plays out a segment descriptor one segment per transfer
module aus_expand (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               desc_load,
	input  aus_pkg::seg_desc_t desc,
	output logic               load_ok,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast,
	output logic [2:0]         m_tuser
);
	import aus_pkg::*;

	logic      valid_s2;
	seg_desc_t desc_s2;
	logic      last;
	logic      take;

	always_comb begin
		if (desc_s2.head_v) begin
			last = (desc_s2.ones == '0) && !desc_s2.tail_v;
		end else if (desc_s2.ones != '0) begin
			last = (desc_s2.ones == CNT_W'(1)) && !desc_s2.tail_v;
		end else begin
			last = 1'b1;
		end
	end

	assign take = valid_s2 && m_tready;
	assign load_ok = !valid_s2 || (m_tready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_ok) begin
			valid_s2 <= desc_load;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			desc_s2 <= desc;
		end else if (take) begin
			if (desc_s2.head_v) begin
				desc_s2.head_v <= 1'b0;
			end else if (desc_s2.ones != '0) begin
				desc_s2.ones <= desc_s2.ones - 1'b1;
			end else begin
				desc_s2.tail_v <= 1'b0;
			end
		end
	end

	always_comb begin
		m_tvalid = valid_s2;
		m_tlast = desc_s2.eos && last;
		if (desc_s2.head_v) begin
			m_tdata = desc_s2.head_len;
			m_tuser = {last, desc_s2.head_kind};
		end else if (desc_s2.ones != '0) begin
			m_tdata = BYTE_W'(1);
			m_tuser = {last, KIND_TEXT};
		end else begin
			m_tdata = desc_s2.tail_len;
			m_tuser = {last, desc_s2.tail_kind};
		end
	end

endmodule

// ----- rtl/ansi_utf8_segmenter_top.sv -----
// Path: input register and parser, then the result register offers the segments.
// Throughput: one byte per cycle while m_tready is high and no byte closes more
// than one segment; a byte closing N segments holds the result register for N transfers.
// Bytes that close nothing pass the parser without touching the result register.
// Reset: arst_n clears the parser to idle and empties both registers at once.
module ansi_utf8_segmenter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // seg_len
	output logic       m_tlast,   // string_done
	output logic [2:0] m_tuser    // seg_kind [1:0], run_last [2]
);
	import aus_pkg::*;

	seg_desc_t desc;
	logic      desc_load;
	logic      load_ok;

	aus_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.load_ok  (load_ok),
		.desc_load(desc_load),
		.desc     (desc)
	);

	aus_expand u_expand (
		.clk      (clk),
		.arst_n   (arst_n),
		.desc_load(desc_load),
		.desc     (desc),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// end of string is always the last segment of its byte
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[2])
		else $error("string_done without run_last");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 8'd0)
		else $error("zero-length segment");

	a_esc_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_ESC |-> m_tdata == 8'd2)
		else $error("two-byte escape with wrong length");

	a_csi_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_CSI
			|-> m_tdata >= 8'd3 && m_tdata <= 8'(MAX_ESC_LEN))
		else $error("control sequence length out of range");

endmodule
